// ===== rtl/core/column_fill_rle_image_decoder_core_assert.svh =====
// Assertion macros for the column-fill RLE image decoder core.
`ifndef COLUMN_FILL_RLE_IMAGE_DECODER_CORE_ASSERT_SVH
`define COLUMN_FILL_RLE_IMAGE_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH
`define CFRLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfrle assertion failed");
`define CFRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfrle assertion failed");
`else
`define CFRLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CFRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/cfrle_pkg.sv =====
// Types, codes and helpers shared by the column-fill RLE image decoder.
package cfrle_pkg;

    localparam int CFG_W   = 10;
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 17;
    localparam int CNT_W   = 16;
    localparam int EPOCH_W = 8;
    localparam int PH_W    = 3;

    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 10'd320;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 10'd200;

    localparam logic [BYTE_W-1:0] HDR_FILL16 = 8'h7F;
    localparam logic [BYTE_W-1:0] HDR_SKIP16 = 8'hFF;

    localparam logic [PH_W-1:0] PH_HEADER  = 3'd0;
    localparam logic [PH_W-1:0] PH_LITERAL = 3'd1;
    localparam logic [PH_W-1:0] PH_COLOUR  = 3'd2;
    localparam logic [PH_W-1:0] PH_FILL_LO = 3'd3;
    localparam logic [PH_W-1:0] PH_FILL_HI = 3'd4;
    localparam logic [PH_W-1:0] PH_SKIP_LO = 3'd5;
    localparam logic [PH_W-1:0] PH_SKIP_HI = 3'd6;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic  written;
        t_byte colour;
    } t_pix_entry;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        t_byte              colour;
    } t_carry_entry;

    function automatic logic [POS_W-1:0] f_advance(input logic [POS_W-1:0] pos,
                                                   input logic [CNT_W-1:0] n);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + (POS_W+1)'(n);
        return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/core/column_fill_rle_image_decoder_core.sv =====
// Top level of the column-fill RLE image decoder core.
// Sequencing: a compressed byte is transferred in the idle state and then executed; a fill
// run then writes one pixel store entry per cycle, and a run that reaches past the frame
// ends with its remaining count skipped. A pixel read steps through transfer, execute,
// store and column-carry memory read, then carry write-back with output load, which waits
// while the output is held; after a frame size write the first read first finds the
// column as a serial remainder of the read address. The pixel store is single ported, so
// decode writes and readout take turns. After reset and after each start command the core
// clears the pixel store and column carry with the input stalled; per frame the carry is
// cleared by an epoch tag; every 256th frame wrap clears it before the next read ends.
`include "column_fill_rle_image_decoder_core_assert.svh"

module column_fill_rle_image_decoder_core
    import cfrle_pkg::*;
#(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_WIDTH  = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_pixel,
    output logic              o_last_pixel,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int A_W     = $clog2(MAX_PIXELS);
    localparam int C_W     = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int T_W     = $clog2(MAX_PIXELS + 1);
    localparam int PR_W    = W_W + CFG_W;
    localparam int EW      = (W_W > CFG_W) ? W_W : CFG_W;
    localparam int CW0     = (PR_W > T_W) ? PR_W : T_W;
    localparam int CW      = (CW0 > POS_W + 1) ? CW0 : POS_W + 1;
    localparam int SWEEP_N = (MAX_PIXELS > MAX_WIDTH) ? MAX_PIXELS : MAX_WIDTH;
    localparam int SW_W    = $clog2(SWEEP_N);
    localparam int MC_W    = $clog2(A_W + 1);
    localparam int PIX_DW  = $bits(t_pix_entry);
    localparam int CAR_DW  = $bits(t_carry_entry);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EXEC      = 3'd1;
    localparam logic [2:0] ST_FILL      = 3'd2;
    localparam logic [2:0] ST_MOD       = 3'd3;
    localparam logic [2:0] ST_RD        = 3'd4;
    localparam logic [2:0] ST_CALC      = 3'd5;
    localparam logic [2:0] ST_CLR_ALL   = 3'd6;
    localparam logic [2:0] ST_CLR_CARRY = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_ret, n_ret;
    logic [OP_W-1:0]    r_op, n_op;
    t_byte              r_byte, n_byte;
    logic [CFG_W-1:0]   r_width, n_width;
    logic [CFG_W-1:0]   r_height, n_height;
    logic [T_W-1:0]     r_total;
    logic [PH_W-1:0]    r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    t_byte              r_lo, n_lo;
    logic [POS_W-1:0]   r_wr_pos, n_wr_pos;
    logic [A_W-1:0]     r_rd_pos, n_rd_pos;
    logic [C_W-1:0]     r_rd_col, n_rd_col;
    logic               r_col_stale, n_col_stale;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [SW_W-1:0]    r_sweep, n_sweep;
    logic [A_W-1:0]     r_mod_sh, n_mod_sh;
    logic [C_W-1:0]     r_mod_rem, n_mod_rem;
    logic [MC_W-1:0]    r_mod_cnt, n_mod_cnt;
    logic               r_o_valid, n_o_valid;
    t_byte              r_o_pixel, n_o_pixel;
    logic               r_o_last, n_o_last;

    logic [EW-1:0]      w_width_ext;
    logic [W_W-1:0]     w_weff;
    logic [CFG_W-1:0]   w_heff;
    logic [PR_W-1:0]    w_prod;
    logic [T_W-1:0]     w_total;
    logic               w_wr_in;
    logic [A_W-1:0]     w_wr_addr;
    logic               w_out_free;
    logic               w_last;
    logic [C_W-1:0]     w_col_next;
    logic [C_W:0]       w_rem_sh;
    logic [C_W-1:0]     w_rem_new;
    t_byte              w_colour;
    logic [EPOCH_W-1:0] w_epoch_inc;

    logic               pix_we, pix_re;
    logic [A_W-1:0]     pix_addr;
    t_pix_entry         pix_wdata, pix_rdata;
    logic               car_we, car_re;
    logic [C_W-1:0]     car_addr;
    t_carry_entry       car_wdata, car_rdata;

    cfrle_ram #(
        .WIDTH (PIX_DW),
        .DEPTH (MAX_PIXELS)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_re    (pix_re),
        .i_addr  (pix_addr),
        .i_wdata (pix_wdata),
        .o_rdata (pix_rdata)
    );

    cfrle_ram #(
        .WIDTH (CAR_DW),
        .DEPTH (MAX_WIDTH)
    ) u_carry_ram (
        .i_clk   (i_clk),
        .i_we    (car_we),
        .i_re    (car_re),
        .i_addr  (car_addr),
        .i_wdata (car_wdata),
        .o_rdata (car_rdata)
    );

    // frame geometry
    always_comb begin
        w_width_ext = EW'(r_width);
        if (r_width == '0) begin
            w_weff = W_W'(1);
        end else if (w_width_ext > EW'(MAX_WIDTH)) begin
            w_weff = W_W'(MAX_WIDTH);
        end else begin
            w_weff = W_W'(r_width);
        end
        w_heff  = (r_height == '0) ? CFG_W'(1) : r_height;
        w_prod  = PR_W'(w_weff) * PR_W'(w_heff);
        w_total = (CW'(w_prod) > CW'(MAX_PIXELS)) ? T_W'(MAX_PIXELS) : T_W'(w_prod);
    end

    assign w_wr_in     = CW'(r_wr_pos) < CW'(r_total);
    assign w_wr_addr   = A_W'(r_wr_pos);
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_last      = (T_W'(r_rd_pos) + T_W'(1)) == r_total;
    assign w_col_next  = ((W_W'(r_rd_col) + W_W'(1)) == w_weff) ? '0 : r_rd_col + C_W'(1);
    assign w_rem_sh    = {r_mod_rem, r_mod_sh[A_W-1]};
    assign w_rem_new   = (w_rem_sh >= (C_W+1)'(w_weff)) ?
                         C_W'(w_rem_sh - (C_W+1)'(w_weff)) : C_W'(w_rem_sh);
    assign w_colour    = pix_rdata.written ? pix_rdata.colour :
                         ((car_rdata.tag == r_epoch) ? car_rdata.colour : '0);
    assign w_epoch_inc = r_epoch + EPOCH_W'(1);

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_pixel      = r_o_pixel;
    assign o_last_pixel = r_o_last;

    // memory ports
    always_comb begin
        pix_we    = 1'b0;
        pix_re    = 1'b0;
        pix_addr  = w_wr_addr;
        pix_wdata = '{written: 1'b1, colour: r_byte};
        car_we    = 1'b0;
        car_re    = 1'b0;
        car_addr  = r_rd_col;
        car_wdata = '{tag: r_epoch, colour: w_colour};
        case (r_state)
            ST_EXEC: begin
                pix_we = (r_op == OP_BYTE) && (r_phase == PH_LITERAL) && w_wr_in;
            end
            ST_FILL: begin
                pix_we = w_wr_in;
            end
            ST_RD: begin
                pix_re   = 1'b1;
                pix_addr = r_rd_pos;
                car_re   = 1'b1;
            end
            ST_CALC: begin
                car_we = w_out_free;
            end
            ST_CLR_ALL: begin
                pix_we    = ({1'b0, r_sweep} < (SW_W+1)'(MAX_PIXELS));
                pix_addr  = A_W'(r_sweep);
                pix_wdata = '0;
                car_we    = ({1'b0, r_sweep} < (SW_W+1)'(MAX_WIDTH));
                car_addr  = C_W'(r_sweep);
                car_wdata = '0;
            end
            ST_CLR_CARRY: begin
                car_we    = 1'b1;
                car_addr  = C_W'(r_sweep);
                car_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    // control
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_op        = r_op;
        n_byte      = r_byte;
        n_width     = r_width;
        n_height    = r_height;
        n_phase     = r_phase;
        n_count     = r_count;
        n_lo        = r_lo;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;
        n_rd_col    = r_rd_col;
        n_col_stale = r_col_stale;
        n_epoch     = r_epoch;
        n_sweep     = r_sweep;
        n_mod_sh    = r_mod_sh;
        n_mod_rem   = r_mod_rem;
        n_mod_cnt   = r_mod_cnt;
        n_o_valid   = r_o_valid && i_stall;
        n_o_pixel   = r_o_pixel;
        n_o_last    = r_o_last;

        if (i_cfg_we) begin
            n_col_stale = 1'b1;
            case (i_cfg_index)
                CFG_IDX_WIDTH:  n_width  = i_cfg_data;
                CFG_IDX_HEIGHT: n_height = i_cfg_data;
                default: begin
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op    = i_op;
                    n_byte  = i_data_byte;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_op)
                    OP_START: begin
                        n_phase     = PH_HEADER;
                        n_count     = '0;
                        n_lo        = '0;
                        n_wr_pos    = '0;
                        n_rd_pos    = '0;
                        n_rd_col    = '0;
                        n_col_stale = 1'b0;
                        n_epoch     = '0;
                        n_sweep     = '0;
                        n_state     = ST_CLR_ALL;
                    end
                    OP_BYTE: begin
                        case (r_phase)
                            PH_LITERAL: begin
                                n_wr_pos = f_advance(r_wr_pos, CNT_W'(1));
                                n_count  = r_count - CNT_W'(1);
                                if (r_count == CNT_W'(1)) begin
                                    n_phase = PH_HEADER;
                                end
                            end
                            PH_COLOUR: begin
                                if (r_count == '0) begin
                                    n_phase = PH_HEADER;
                                end else begin
                                    n_state = ST_FILL;
                                end
                            end
                            PH_FILL_LO: begin
                                n_lo    = r_byte;
                                n_phase = PH_FILL_HI;
                            end
                            PH_FILL_HI: begin
                                n_count = {r_byte, r_lo};
                                n_phase = PH_COLOUR;
                            end
                            PH_SKIP_LO: begin
                                n_lo    = r_byte;
                                n_phase = PH_SKIP_HI;
                            end
                            PH_SKIP_HI: begin
                                n_wr_pos = f_advance(r_wr_pos, {r_byte, r_lo});
                                n_phase  = PH_HEADER;
                            end
                            default: begin
                                if (r_byte == HDR_FILL16) begin
                                    n_phase = PH_FILL_LO;
                                end else if (r_byte == HDR_SKIP16) begin
                                    n_phase = PH_SKIP_LO;
                                end else if (r_byte[7]) begin
                                    n_wr_pos = f_advance(r_wr_pos,
                                                         CNT_W'(r_byte[6:0]) + CNT_W'(1));
                                    n_phase  = PH_HEADER;
                                end else if (r_byte[6]) begin
                                    n_count = CNT_W'(r_byte[5:0]) + CNT_W'(1);
                                    n_phase = PH_COLOUR;
                                end else begin
                                    n_count = CNT_W'(r_byte[5:0]) + CNT_W'(1);
                                    n_phase = PH_LITERAL;
                                end
                            end
                        endcase
                    end
                    OP_READ: begin
                        if (T_W'(r_rd_pos) >= r_total) begin
                            n_rd_pos    = '0;
                            n_rd_col    = '0;
                            n_col_stale = 1'b0;
                            n_epoch     = w_epoch_inc;
                            if (w_epoch_inc == '0) begin
                                n_sweep = '0;
                                n_ret   = ST_RD;
                                n_state = ST_CLR_CARRY;
                            end else begin
                                n_state = ST_RD;
                            end
                        end else if (r_col_stale) begin
                            n_mod_sh  = r_rd_pos;
                            n_mod_rem = '0;
                            n_mod_cnt = '0;
                            n_state   = ST_MOD;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FILL: begin
                if (!w_wr_in) begin
                    n_wr_pos = f_advance(r_wr_pos, r_count);
                    n_count  = '0;
                    n_phase  = PH_HEADER;
                    n_state  = ST_IDLE;
                end else begin
                    n_wr_pos = f_advance(r_wr_pos, CNT_W'(1));
                    n_count  = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_phase = PH_HEADER;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MOD: begin
                n_mod_rem = w_rem_new;
                n_mod_sh  = r_mod_sh << 1;
                n_mod_cnt = r_mod_cnt + MC_W'(1);
                if (r_mod_cnt == MC_W'(A_W - 1)) begin
                    n_rd_col    = w_rem_new;
                    n_col_stale = 1'b0;
                    n_state     = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_pixel = w_colour;
                    n_o_last  = w_last;
                    n_state   = ST_IDLE;
                    if (w_last) begin
                        n_rd_pos = '0;
                        n_rd_col = '0;
                        n_epoch  = w_epoch_inc;
                        if (w_epoch_inc == '0) begin
                            n_sweep = '0;
                            n_ret   = ST_IDLE;
                            n_state = ST_CLR_CARRY;
                        end
                    end else begin
                        n_rd_pos = r_rd_pos + A_W'(1);
                        n_rd_col = w_col_next;
                    end
                end
            end
            ST_CLR_ALL: begin
                n_sweep = r_sweep + SW_W'(1);
                if (r_sweep == SW_W'(SWEEP_N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLR_CARRY: begin
                n_sweep = r_sweep + SW_W'(1);
                if (r_sweep == SW_W'(MAX_WIDTH - 1)) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR_ALL;
            r_ret       <= ST_IDLE;
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_lo        <= '0;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_rd_col    <= '0;
            r_col_stale <= 1'b0;
            r_epoch     <= '0;
            r_sweep     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_width     <= n_width;
            r_height    <= n_height;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_lo        <= n_lo;
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
            r_rd_col    <= n_rd_col;
            r_col_stale <= n_col_stale;
            r_epoch     <= n_epoch;
            r_sweep     <= n_sweep;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_byte    <= n_byte;
        r_total   <= w_total;
        r_mod_sh  <= n_mod_sh;
        r_mod_rem <= n_mod_rem;
        r_mod_cnt <= n_mod_cnt;
        r_o_pixel <= n_o_pixel;
        r_o_last  <= n_o_last;
    end

    `CFRLE_ASSERT_NEXT(a_wr_pos_forward, i_clk, i_rst_n, !(r_state == ST_EXEC && r_op == OP_START), r_wr_pos >= $past(r_wr_pos))
    `CFRLE_ASSERT_IMPL(a_fill_nonzero, i_clk, i_rst_n, r_state == ST_FILL, r_count != '0)
    `CFRLE_ASSERT_NEXT(a_out_from_calc, i_clk, i_rst_n, r_state != ST_CALC, !$rose(r_o_valid))
    `CFRLE_ASSERT_IMPL(a_col_in_row, i_clk, i_rst_n, r_state == ST_RD, CW'(r_rd_col) < CW'(w_weff))
    `CFRLE_ASSERT_IMPL(a_rd_in_frame, i_clk, i_rst_n, r_state == ST_CALC, T_W'(r_rd_pos) < r_total)

endmodule

// ===== rtl/core/cfrle_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module cfrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/tb_column_fill_rle_image_decoder_core.sv =====
// Self-checking testbench for the column-fill RLE image decoder core.
`timescale 1ns / 100ps

module tb_column_fill_rle_image_decoder_core;
    import cfrle_pkg::*;

    localparam int MAX_PIX = 65536;
    localparam int MAX_COLS = 512;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic [BYTE_W-1:0] HDR_FILL_BASE = 8'h40;
    localparam logic [BYTE_W-1:0] HDR_SKIP_BASE = 8'h80;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES = 64;
    localparam longint LIMIT_CYCLES = 10_000_000;
    localparam int PHASE_ITEMS = 160;
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              last;
    } t_pixel_rec;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic [BYTE_W-1:0] pixel;
        logic              last;
    } t_stim_row;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             fresh;
    } t_frame_setup;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_op;
    logic [BYTE_W-1:0] i_data_byte;
    logic              o_valid;
    logic              i_stall;
    logic [BYTE_W-1:0] o_pixel;
    logic              o_last_pixel;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    column_fill_rle_image_decoder_core #(
        .MAX_PIXELS(MAX_PIX),
        .MAX_WIDTH (MAX_COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel     (o_pixel),
        .o_last_pixel(o_last_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // frame is 3 x 2 during this table
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{OP_READ,  8'h00, 1'b1, 8'h00, 1'b0},
        '{OP_NONE,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h02, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'hAA, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h40, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h55, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h80, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h7E, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h11, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h7F, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'h22, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_BYTE,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'h00, 1'b1, 8'h11, 1'b1},
        '{OP_READ,  8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_START, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    t_frame_setup phase_setups [N_PHASES] = '{
        '{10'd5,    10'd4,    1'b1},
        '{10'd17,   10'd9,    1'b0},
        '{10'd1,    10'd1,    1'b1},
        '{10'd0,    10'd7,    1'b0},
        '{10'd1023, 10'd0,    1'b1},
        '{10'd512,  10'd512,  1'b1},
        '{10'd3,    10'd1023, 1'b0},
        '{10'd8,    10'd6,    1'b1}
    };

    // decoder image of the block
    logic [CFG_W-1:0]  frame_w;
    logic [CFG_W-1:0]  frame_h;
    logic [PH_W-1:0]   parse_state;
    logic [CNT_W-1:0]  run_left;
    logic [BYTE_W-1:0] count_lo;
    logic [POS_W-1:0]  wr_pos;
    int unsigned       rd_pos;
    logic [BYTE_W-1:0] frame_mem [MAX_PIX];
    bit                painted [MAX_PIX];
    logic [BYTE_W-1:0] col_colour [MAX_COLS];

    t_pixel_rec  pixels_due [$];
    t_pixel_rec  due_pix;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned send_idle_pct = 10;
    int unsigned recv_stall_pct = 53;
    bit          hold_req = 1'b0;
    int          hold_count;
    longint      cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned cols_now();
        int unsigned w;
        w = frame_w;
        if (w < 1) w = 1;
        if (w > MAX_COLS) w = MAX_COLS;
        return w;
    endfunction

    function automatic int unsigned pixels_now();
        int unsigned h;
        int unsigned t;
        h = (frame_h < 1) ? 1 : frame_h;
        t = cols_now() * h;
        if (t > MAX_PIX) t = MAX_PIX;
        return t;
    endfunction

    function automatic void skip_ahead(input int unsigned n);
        int unsigned p;
        p = wr_pos + n;
        wr_pos = (p > POS_MAX) ? POS_MAX : POS_W'(p);
    endfunction

    function automatic void paint(input logic [BYTE_W-1:0] c);
        if (wr_pos < pixels_now()) begin
            frame_mem[wr_pos] = c;
            painted[wr_pos] = 1'b1;
        end
        skip_ahead(1);
    endfunction

    function automatic void clear_carry();
        foreach (col_colour[i]) col_colour[i] = '0;
    endfunction

    function automatic void open_image();
        parse_state = PH_HEADER;
        run_left = '0;
        count_lo = '0;
        wr_pos = '0;
        rd_pos = 0;
        foreach (painted[i]) painted[i] = 1'b0;
        clear_carry();
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        int unsigned k;
        case (parse_state)
            PH_LITERAL: begin
                paint(b);
                run_left = run_left - 16'd1;
                if (run_left == '0) parse_state = PH_HEADER;
            end
            PH_COLOUR: begin
                for (k = 0; k < run_left; k++) paint(b);
                run_left = '0;
                parse_state = PH_HEADER;
            end
            PH_FILL_LO: begin
                count_lo = b;
                parse_state = PH_FILL_HI;
            end
            PH_FILL_HI: begin
                run_left = {b, count_lo};
                parse_state = PH_COLOUR;
            end
            PH_SKIP_LO: begin
                count_lo = b;
                parse_state = PH_SKIP_HI;
            end
            PH_SKIP_HI: begin
                skip_ahead({b, count_lo});
                parse_state = PH_HEADER;
            end
            default: begin
                if (b == HDR_FILL16) begin
                    parse_state = PH_FILL_LO;
                end else if (b == HDR_SKIP16) begin
                    parse_state = PH_SKIP_LO;
                end else if (b[7]) begin
                    skip_ahead(int'(b[6:0]) + 1);
                    parse_state = PH_HEADER;
                end else if (b[6]) begin
                    run_left = b[5:0] + 16'd1;
                    parse_state = PH_COLOUR;
                end else begin
                    run_left = b[5:0] + 16'd1;
                    parse_state = PH_LITERAL;
                end
            end
        endcase
    endfunction

    function automatic bit decode_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                                       output t_pixel_rec r);
        int unsigned total;
        int unsigned col;
        decode_step = 1'b0;
        r = '0;
        case (op)
            OP_START: open_image();
            OP_BYTE:  parse_byte(b);
            OP_READ: begin
                total = pixels_now();
                if (rd_pos >= total) begin
                    rd_pos = 0;
                    clear_carry();
                end
                col = rd_pos % cols_now();
                if (painted[rd_pos]) col_colour[col] = frame_mem[rd_pos];
                r.pixel = col_colour[col];
                r.last = (rd_pos + 1 == total);
                if (r.last) begin
                    rd_pos = 0;
                    clear_carry();
                end else begin
                    rd_pos++;
                end
                decode_step = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic put_row(input t_stim_row row);
        t_pixel_rec r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= row.op;
        i_data_byte <= row.data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (decode_step(row.op, row.data, r)) begin
            if (row.typed) begin
                r.pixel = row.pixel;
                r.last = row.last;
            end
            pixels_due.push_back(r);
        end
        if (row.op != OP_NONE) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        put_row(t_stim_row'{op, b, 1'b0, 8'h00, 1'b0});
    endtask

    task automatic put_read();
        put_item(OP_READ, 8'($urandom_range(255)));
    endtask

    // stream byte, sometimes with a read slipped in ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 8) put_read();
        put_item(OP_BYTE, b);
    endtask

    // end on a read so that any fill run has finished once its pixel is back
    task automatic wait_idle();
        put_read();
        i_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_IDX_WIDTH;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_IDX_HEIGHT;
        i_cfg_data <= h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        frame_w = w;
        frame_h = h;
    endtask

    task automatic emit_segment();
        int kind;
        int n;
        int k;
        int pick;
        logic [CNT_W-1:0] cnt;
        kind = $urandom_range(99);
        if (kind < 18) begin
            if ($urandom_range(9) == 0) n = $urandom_range(1) ? 63 : $urandom_range(63);
            else n = $urandom_range(7);
            send_byte(8'(n));
            for (k = 0; k <= n; k++) send_byte(8'($urandom_range(255)));
        end else if (kind < 32) begin
            send_byte(HDR_FILL_BASE + 8'($urandom_range(62)));
            send_byte(8'($urandom_range(255)));
        end else if (kind < 42) begin
            pick = $urandom_range(59);
            if (pick == 0) cnt = '0;
            else if (pick == 1) cnt = 16'hFFFF;
            else if (pick == 2) cnt = 16'($urandom_range(65535));
            else cnt = 16'($urandom_range(40));
            send_byte(HDR_FILL16);
            send_byte(cnt[7:0]);
            send_byte(cnt[15:8]);
            send_byte(8'($urandom_range(255)));
        end else if (kind < 50) begin
            send_byte(HDR_SKIP_BASE + 8'($urandom_range(126)));
        end else if (kind < 58) begin
            pick = $urandom_range(9);
            if (pick == 0) cnt = '0;
            else if (pick == 1) cnt = 16'hFFFF;
            else if (pick == 2) cnt = 16'($urandom_range(65535));
            else cnt = 16'($urandom_range(64));
            send_byte(HDR_SKIP16);
            send_byte(cnt[7:0]);
            send_byte(cnt[15:8]);
        end else if (kind < 60) begin
            // drives the write position into saturation
            repeat (3) begin
                send_byte(HDR_SKIP16);
                send_byte(8'hFF);
                send_byte(8'hFF);
            end
        end else if (kind < 88) begin
            repeat ($urandom_range(6, 1)) put_read();
        end else begin
            put_item($urandom_range(1) ? OP_BYTE : OP_NONE, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixels_due.size() == 0) begin
                $error("pixel transfer with nothing pending: pixel %0h last_pixel %0b",
                       o_pixel, o_last_pixel);
                mismatches++;
            end else begin
                due_pix = pixels_due.pop_front();
                if (o_pixel !== due_pix.pixel) begin
                    $error("pixel: expected %0h, got %0h", due_pix.pixel, o_pixel);
                    mismatches++;
                end
                if (o_last_pixel !== due_pix.last) begin
                    $error("last_pixel: expected %0b, got %0b", due_pix.last, o_last_pixel);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int d;
        int p;
        int unsigned phase_end;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op <= OP_START;
        i_data_byte <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_IDX_WIDTH;
        i_cfg_data <= '0;
        frame_w = RESET_WIDTH;
        frame_h = RESET_HEIGHT;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        open_image();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_frame(10'd3, 10'd2);
        for (d = 0; d < N_DIRECTED; d++) put_row(directed_rows[d]);
        wait_idle();
        for (p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 53;
                recv_stall_pct = 10;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            set_frame(phase_setups[p].width, phase_setups[p].height);
            if (phase_setups[p].fresh) put_item(OP_START, 8'($urandom_range(255)));
            if (p == 1) begin
                hold_req = 1'b1;
                repeat (40) put_read();
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) emit_segment();
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cfrle_pkg.sv
rtl/core/cfrle_ram.sv
rtl/core/column_fill_rle_image_decoder_core.sv
dv/tb_column_fill_rle_image_decoder_core.sv
